@@ rtl/lphm_pkg.sv @@
package lphm_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int Q_DEPTH = 2;
	localparam int R_DEPTH = 2;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int MIX_SH1 = 30;
	localparam int MIX_SH2 = 27;
	localparam int MIX_SH3 = 31;

	localparam int MOD_BITS = 4;
	localparam int MOD_STEPS = 64 / MOD_BITS;
	localparam int DIG_W = $clog2(MOD_STEPS);

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;
	localparam logic [1:0] PH_END = 2'd3;

	localparam int CNT_SAT = 31;

	typedef enum logic [1:0] {
		REQ_GET = 2'd0,
		REQ_SET = 2'd1,
		REQ_DEL = 2'd2
	} lphm_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} lphm_status_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_XS,
		F_MUL,
		F_FIN,
		F_MOD,
		F_PUSH
	} lphm_fstate_t;

	typedef enum logic [2:0] {
		B_CLR,
		B_IDLE,
		B_RD,
		B_CHK,
		B_DONE
	} lphm_bstate_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] key;
		logic [63:0] new_value;
	} lphm_req_t;

	typedef struct packed {
		logic [63:0]  read_value;
		lphm_status_t status;
		logic [4:0]   live_count;
	} lphm_res_t;

	typedef struct packed {
		logic        used;
		logic        tomb;
		logic [63:0] key;
		logic [63:0] data;
	} lphm_slot_t;

endpackage

@@ rtl/linear_probe_hash_map_top.sv @@
// Hash map of 64-bit keys to 64-bit values over CAPACITY slots, linear probing.
// Requests enter on a queue-style port: an item transfers at a clock edge with
// push high and full low. Results leave the same way: the oldest result is on
// read_value, status and live_count while empty is low, and it transfers at a
// clock edge with pop high. Every request gives exactly one result, in order.
// The front unit works on one request at a time and keeps full high while busy.
// It hashes the key with one shared 32x32 multiplier, plus a 4-bit-per-cycle
// remainder when CAPACITY is not a power of two, and then hands the key and its
// home slot on to the request queue, stalling while that queue is full. The
// back unit takes a request from the queue, starts the first slot read, checks
// the slots along the probe walk, and hands over the result, stalling while
// the result queue is full. A two-entry queue separates the two, so the rate
// is set by the slower unit. After reset the slot memory is cleared slot by
// slot; full stays high until that is done. If the receiver stops popping,
// the two-entry result queue fills, the back unit stalls, and full stays high
// once the request queue and the front unit are both occupied. No transfer
// is lost.
module linear_probe_hash_map_top #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic signed [63:0] key,
	input  logic signed [63:0] new_value,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] read_value,
	output logic [1:0]         status,
	output logic [4:0]         live_count
);

	import lphm_pkg::*;

	localparam int IDXW = $clog2(CAPACITY);
	localparam int QW = $bits(lphm_req_t) + IDXW;
	localparam int RW = $bits(lphm_res_t);

	lphm_req_t       in_item;
	lphm_req_t       f_item;
	logic [IDXW-1:0] f_home;
	logic            f_push;
	lphm_req_t       b_item;
	logic [IDXW-1:0] b_home;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	logic [QW-1:0]   q_rd;
	logic            r_full;
	logic            r_push;
	lphm_res_t       r_wr;
	lphm_res_t       r_out;
	logic [RW-1:0]   r_rd;
	logic            clearing;

	assign in_item = '{req_type: req_type, key: key, new_value: new_value};
	assign {b_item, b_home} = q_rd;
	assign r_out = r_rd;
	assign read_value = r_out.read_value;
	assign status = r_out.status;
	assign live_count = r_out.live_count;

	lphm_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.hold   (clearing),
		.req_in (in_item),
		.full   (full),
		.q_push (f_push),
		.q_item (f_item),
		.q_home (f_home),
		.q_full (q_full)
	);

	lphm_fifo #(
		.WIDTH (QW),
		.DEPTH (Q_DEPTH)
	) u_req_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data ({f_item, f_home}),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	lphm_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_item   (b_item),
		.q_home   (b_home),
		.r_full   (r_full),
		.r_push   (r_push),
		.r_data   (r_wr),
		.clearing (clearing)
	);

	lphm_fifo #(
		.WIDTH (RW),
		.DEPTH (R_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (r_push),
		.wr_data (r_wr),
		.full    (r_full),
		.rd_en   (pop),
		.rd_data (r_rd),
		.empty   (empty)
	);

endmodule

@@ rtl/lphm_fifo.sv @@
module lphm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_fifo_level: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue level beyond its depth");

	a_fifo_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue reported full and empty at once");

	a_fifo_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q <= PTR_LAST) && (rptr_q <= PTR_LAST))
		else $error("queue pointer beyond its depth");
`endif

endmodule

@@ rtl/lphm_front.sv @@
module lphm_front #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          hold,
	input  lphm_pkg::lphm_req_t           req_in,
	output logic                          full,
	output logic                          q_push,
	output lphm_pkg::lphm_req_t           q_item,
	output logic [$clog2(CAPACITY)-1:0]   q_home,
	input  logic                          q_full
);

	import lphm_pkg::*;

	localparam int IDXW = $clog2(CAPACITY);
	localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
	localparam logic [IDXW:0] CAP_W = (IDXW + 1)'(CAPACITY);

	lphm_fstate_t      fs_q;
	lphm_fstate_t      fs_nx;
	logic              round_q;
	logic [1:0]        ph_q;
	logic [DIG_W-1:0]  dig_q;
	lphm_req_t         req_q;
	logic [63:0]       x_q;
	logic [63:0]       acc_q;
	logic [63:0]       prod_q;
	logic [63:0]       h_q;
	logic [IDXW-1:0]   rem_q;
	logic              accept;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul;
	logic [63:0]       cst;
	logic [63:0]       hfin;
	logic [IDXW-1:0]   mod_r;

	assign accept = push & ~full;
	assign cst = round_q ? MIX_C2 : MIX_C1;
	assign mul = mul_a * mul_b;
	assign hfin = acc_q ^ (acc_q >> MIX_SH3);

	always_comb begin
		case (ph_q)
			PH_LL: begin
				mul_a = x_q[31:0];
				mul_b = cst[31:0];
			end
			PH_LH: begin
				mul_a = x_q[31:0];
				mul_b = cst[63:32];
			end
			default: begin
				mul_a = x_q[63:32];
				mul_b = cst[31:0];
			end
		endcase
	end

	always_comb begin
		logic [IDXW:0]   t;
		logic [IDXW-1:0] r;
		r = rem_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			t = {r, h_q[63 - i]};
			if (t >= CAP_W) begin
				t = t - CAP_W;
			end
			r = t[IDXW-1:0];
		end
		mod_r = r;
	end

	always_comb begin
		fs_nx = fs_q;
		unique case (fs_q)
			F_IDLE: begin
				if (accept) begin
					fs_nx = F_XS;
				end
			end
			F_XS: fs_nx = F_MUL;
			F_MUL: begin
				if (ph_q == PH_END) begin
					fs_nx = round_q ? F_FIN : F_XS;
				end
			end
			F_FIN: fs_nx = CAP_POW2 ? F_PUSH : F_MOD;
			F_MOD: begin
				if (dig_q == DIG_W'(MOD_STEPS - 1)) begin
					fs_nx = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					fs_nx = F_IDLE;
				end
			end
			default: fs_nx = F_IDLE;
		endcase
	end

	always_comb begin
		full = (fs_q != F_IDLE) | hold;
		q_push = (fs_q == F_PUSH) & ~q_full;
		q_item = req_q;
		q_home = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= F_IDLE;
			round_q <= 1'b0;
			ph_q <= PH_LL;
			dig_q <= '0;
		end else begin
			fs_q <= fs_nx;
			unique case (fs_q)
				F_IDLE: round_q <= 1'b0;
				F_XS: ph_q <= PH_LL;
				F_MUL: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == PH_END) begin
						round_q <= 1'b1;
					end
				end
				F_FIN: dig_q <= '0;
				F_MOD: dig_q <= dig_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (fs_q)
			F_IDLE: begin
				if (accept) begin
					req_q <= req_in;
				end
			end
			F_XS: begin
				x_q <= round_q ? (acc_q ^ (acc_q >> MIX_SH2))
					: (req_q.key ^ (req_q.key >> MIX_SH1));
			end
			F_MUL: begin
				prod_q <= mul;
				case (ph_q)
					PH_LH: acc_q <= prod_q;
					PH_HL, PH_END: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
					default: ;
				endcase
			end
			F_FIN: begin
				h_q <= hfin;
				rem_q <= CAP_POW2 ? hfin[IDXW-1:0] : '0;
			end
			F_MOD: begin
				rem_q <= mod_r;
				h_q <= h_q << MOD_BITS;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/lphm_back.sv @@
module lphm_back #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  lphm_pkg::lphm_req_t           q_item,
	input  logic [$clog2(CAPACITY)-1:0]   q_home,
	input  logic                          r_full,
	output logic                          r_push,
	output lphm_pkg::lphm_res_t           r_data,
	output logic                          clearing
);

	import lphm_pkg::*;

	localparam int IDXW = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam logic [IDXW-1:0] IDX_LAST = IDXW'(CAPACITY - 1);

	lphm_slot_t      slot_mem [CAPACITY];
	lphm_slot_t      rd_q;

	lphm_bstate_t    bs_q;
	lphm_bstate_t    bs_nx;
	logic [IDXW-1:0] clr_q;
	lphm_req_t       req_q;
	logic [IDXW-1:0] idx_q;
	logic [IDXW-1:0] step_q;
	logic            fvld_q;
	logic [IDXW-1:0] fidx_q;
	logic            wen_q;
	logic [IDXW-1:0] widx_q;
	lphm_slot_t      wword_q;
	lphm_status_t    st_q;
	logic [63:0]     rv_q;
	logic            inc_q;
	logic            dec_q;
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] cnt_nx;

	logic [IDXW-1:0] nxt_idx;
	logic            hit;
	logic            blank;
	logic            last;
	logic            stop;
	logic            fr_vld;
	logic [IDXW-1:0] fr_idx;
	logic            d_wen;
	logic [IDXW-1:0] d_widx;
	lphm_slot_t      d_word;
	lphm_status_t    d_st;
	logic [63:0]     d_rv;
	logic            d_inc;
	logic            d_dec;
	logic            done;
	logic            mem_we;
	logic [IDXW-1:0] mem_waddr;
	lphm_slot_t      mem_wdata;
	logic [IDXW-1:0] mem_raddr;

	assign nxt_idx = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
	assign hit = rd_q.used & (rd_q.key == req_q.key);
	assign blank = ~rd_q.used & ~rd_q.tomb;
	assign last = (step_q == IDX_LAST);
	assign stop = hit | blank | last;
	assign fr_vld = fvld_q | ~rd_q.used;
	assign fr_idx = fvld_q ? fidx_q : idx_q;

	always_comb begin
		d_wen = 1'b0;
		d_widx = idx_q;
		d_word = '{used: 1'b1, tomb: 1'b0, key: req_q.key, data: req_q.new_value};
		d_st = ST_NOT_FOUND;
		d_rv = '0;
		d_inc = 1'b0;
		d_dec = 1'b0;
		case (req_q.req_type)
			REQ_GET: begin
				if (hit) begin
					d_st = ST_OK;
					d_rv = rd_q.data;
				end
			end
			REQ_SET: begin
				if (hit) begin
					d_wen = 1'b1;
					d_st = ST_OK;
				end else if (fr_vld) begin
					d_wen = 1'b1;
					d_widx = fr_idx;
					d_inc = 1'b1;
					d_st = ST_OK;
				end else begin
					d_st = ST_FULL;
				end
			end
			REQ_DEL: begin
				if (hit) begin
					d_wen = 1'b1;
					d_word = '{used: 1'b0, tomb: 1'b1, key: rd_q.key, data: rd_q.data};
					d_dec = 1'b1;
					d_st = ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (inc_q) begin
			cnt_nx = cnt_q + 1'b1;
		end else if (dec_q && cnt_q != '0) begin
			cnt_nx = cnt_q - 1'b1;
		end else begin
			cnt_nx = cnt_q;
		end
	end

	always_comb begin
		bs_nx = bs_q;
		unique case (bs_q)
			B_CLR: begin
				if (clr_q == IDX_LAST) begin
					bs_nx = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					if (q_item.req_type == REQ_GET || q_item.req_type == REQ_SET
						|| q_item.req_type == REQ_DEL) begin
						bs_nx = B_RD;
					end else begin
						bs_nx = B_DONE;
					end
				end
			end
			B_RD: bs_nx = B_CHK;
			B_CHK: begin
				if (stop) begin
					bs_nx = B_DONE;
				end
			end
			B_DONE: begin
				if (!r_full) begin
					bs_nx = B_IDLE;
				end
			end
			default: bs_nx = B_IDLE;
		endcase
	end

	always_comb begin
		clearing = (bs_q == B_CLR);
		q_pop = (bs_q == B_IDLE) & ~q_empty;
		done = (bs_q == B_DONE) & ~r_full;
		r_push = done;
		r_data.read_value = rv_q;
		r_data.status = st_q;
		r_data.live_count = (32'(cnt_nx) > 32'(CNT_SAT)) ? 5'(CNT_SAT) : 5'(cnt_nx);
		mem_we = clearing | (done & wen_q);
		mem_waddr = clearing ? clr_q : widx_q;
		mem_wdata = clearing ? '0 : wword_q;
		mem_raddr = (bs_q == B_CHK) ? nxt_idx : idx_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= slot_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= B_CLR;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			bs_q <= bs_nx;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (done) begin
				cnt_q <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (bs_q)
			B_IDLE: begin
				if (!q_empty) begin
					req_q <= q_item;
					idx_q <= q_home;
					step_q <= '0;
					fvld_q <= 1'b0;
					wen_q <= 1'b0;
					st_q <= ST_NOT_FOUND;
					rv_q <= '0;
					inc_q <= 1'b0;
					dec_q <= 1'b0;
				end
			end
			B_CHK: begin
				if (stop) begin
					wen_q <= d_wen;
					widx_q <= d_widx;
					wword_q <= d_word;
					st_q <= d_st;
					rv_q <= d_rv;
					inc_q <= d_inc;
					dec_q <= d_dec;
				end else begin
					fvld_q <= fr_vld;
					fidx_q <= fr_idx;
					idx_q <= nxt_idx;
					step_q <= step_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CAPACITY))
		else $error("live entry count exceeds the capacity");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("request taken while the slot table is being cleared");

	a_full_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		(r_push && r_data.status == ST_FULL) |-> (req_q.req_type == REQ_SET))
		else $error("table full reported for a request other than set");

	a_write_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clearing) |-> r_push)
		else $error("slot written without a result transfer");
`endif

endmodule

@@ tb/sv/lphm_reply_checker.sv @@
module lphm_reply_checker #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  req_type,
	input  logic [63:0] key,
	input  logic [63:0] new_value,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] read_value,
	input  logic [1:0]  status,
	input  logic [4:0]  live_count,
	output int          fail_count,
	output int          pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import lphm_pkg::*;

	typedef struct {
		logic [63:0]  rd;
		lphm_status_t st;
		logic [4:0]   cnt;
	} reply_t;

	logic [63:0] tbl_key [CAPACITY];
	logic [63:0] tbl_data [CAPACITY];
	bit tbl_live [CAPACITY];
	bit tbl_gone [CAPACITY];
	int unsigned live_total;

	reply_t owed_replies [$];
	int mismatches = 0;
	int owed_now = 0;

	assign fail_count = mismatches;
	assign pending = owed_now;

	function automatic int home_slot(logic [63:0] k);
		logic [63:0] h;
		h = (k ^ (k >> MIX_SH1)) * MIX_C1;
		h = (h ^ (h >> MIX_SH2)) * MIX_C2;
		h = h ^ (h >> MIX_SH3);
		return int'(h % 64'(CAPACITY));
	endfunction

	// Walks the probe chain and applies the request to the shadow table.
	// A never-used slot ends the walk; a deleted slot is only remembered
	// as a place to insert.
	function automatic reply_t lookup_and_update(logic [1:0] op, logic [63:0] k,
			logic [63:0] v);
		reply_t r;
		int idx;
		int hit;
		int spare;
		r.rd = '0;
		r.st = ST_NOT_FOUND;
		hit = -1;
		spare = -1;
		if (op == REQ_GET || op == REQ_SET || op == REQ_DEL) begin
			idx = home_slot(k);
			for (int i = 0; i < CAPACITY; i++) begin
				if (tbl_live[idx]) begin
					if (tbl_key[idx] == k) begin
						hit = idx;
						break;
					end
				end else begin
					if (spare < 0)
						spare = idx;
					if (!tbl_gone[idx])
						break;
				end
				idx = (idx + 1) % CAPACITY;
			end
		end
		case (op)
			REQ_GET: begin
				if (hit >= 0) begin
					r.rd = tbl_data[hit];
					r.st = ST_OK;
				end
			end
			REQ_SET: begin
				if (hit >= 0) begin
					tbl_data[hit] = v;
					r.st = ST_OK;
				end else if (spare >= 0) begin
					tbl_key[spare] = k;
					tbl_data[spare] = v;
					tbl_live[spare] = 1'b1;
					tbl_gone[spare] = 1'b0;
					live_total++;
					r.st = ST_OK;
				end else begin
					r.st = ST_FULL;
				end
			end
			REQ_DEL: begin
				if (hit >= 0) begin
					tbl_live[hit] = 1'b0;
					tbl_gone[hit] = 1'b1;
					if (live_total > 0)
						live_total--;
					r.st = ST_OK;
				end
			end
			default: ;
		endcase
		r.cnt = (live_total > CNT_SAT) ? 5'(CNT_SAT) : 5'(live_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				tbl_key[i] = '0;
				tbl_data[i] = '0;
				tbl_live[i] = 1'b0;
				tbl_gone[i] = 1'b0;
			end
			live_total = 0;
			owed_replies.delete();
			owed_now = 0;
		end else begin
			if (pop && !empty) begin
				if (owed_replies.size() == 0) begin
					$display("%0t: result transfer with nothing expected: value %h status %0d count %0d",
						$time, read_value, status, live_count);
					mismatches++;
				end else begin
					want = owed_replies.pop_front();
					if (read_value !== want.rd) begin
						$display("%0t: read_value expected %h actual %h", $time, want.rd,
							read_value);
						mismatches++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						mismatches++;
					end
					if (live_count !== want.cnt) begin
						$display("%0t: live_count expected %0d actual %0d", $time, want.cnt,
							live_count);
						mismatches++;
					end
				end
			end
			if (push && !full)
				owed_replies.push_back(lookup_and_update(req_type, key, new_value));
			owed_now = owed_replies.size();
		end
	end

endmodule

@@ tb/sv/tb_linear_probe_hash_map_top.sv @@
module tb_linear_probe_hash_map_top;

	timeunit 1ns;
	timeprecision 1ps;

	import lphm_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int POOL_N = 20;
	localparam int ROUNDS = 13;
	localparam int ROUND_ITEMS = 100;

	localparam logic [1:0] REQ_BAD = 2'd3;

	localparam int MIX_FILL = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN = 2;

	localparam int RX_FREE = 0;
	localparam int RX_SHORT = 1;
	localparam int RX_LONG = 2;

	localparam logic [63:0] K_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] K_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] K_ZERO = 64'h0;
	localparam logic [63:0] K_ONES = 64'hffff_ffff_ffff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] req_type = REQ_GET;
	logic signed [63:0] key = '0;
	logic signed [63:0] new_value = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [63:0] read_value;
	logic [1:0] status;
	logic [4:0] live_count;

	int fail_count;
	int pending;
	int cycle_count = 0;

	logic [63:0] key_pool [POOL_N];

	linear_probe_hash_map_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.key(key),
		.new_value(new_value),
		.empty(empty),
		.pop(pop),
		.read_value(read_value),
		.status(status),
		.live_count(live_count)
	);

	lphm_reply_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.key(key),
		.new_value(new_value),
		.empty(empty),
		.pop(pop),
		.read_value(read_value),
		.status(status),
		.live_count(live_count),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_linear_probe_hash_map_top failed");
			$finish;
		end
	end

	// The receiver switches between free running, short stalls and long stalls.
	int stall_left = 0;
	int rx_mode = RX_FREE;
	int rx_timer = 0;

	always @(negedge clk) begin
		if (rx_timer == 0) begin
			rx_mode = $urandom_range(RX_FREE, RX_LONG);
			rx_timer = $urandom_range(50, 300);
		end else begin
			rx_timer--;
		end
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else begin
			pop <= 1'b1;
			case (rx_mode)
				RX_SHORT: begin
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 4);
				end
				RX_LONG: begin
					if ($urandom_range(0, 5) == 0)
						stall_left = $urandom_range(5, 40);
				end
				default: ;
			endcase
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 9))
			0: return K_MIN;
			1: return K_MAX;
			2: return K_ZERO;
			default: return rand_word();
		endcase
	endfunction

	function automatic logic [63:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return rand_word();
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_req(logic [1:0] op, logic [63:0] k, logic [63:0] v);
		push <= 1'b1;
		req_type <= op;
		key <= k;
		new_value <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic random_round(int mix, int n);
		int r;
		int burst_left;
		bit gappy;
		logic [1:0] op;
		burst_left = 0;
		gappy = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (gappy && $urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 10));
			end
			burst_left--;
			r = $urandom_range(0, 99);
			if (r < 2) begin
				op = REQ_BAD;
			end else begin
				case (mix)
					MIX_FILL: op = (r < 65) ? REQ_SET : (r < 85) ? REQ_GET : REQ_DEL;
					MIX_DRAIN: op = (r < 60) ? REQ_DEL : (r < 85) ? REQ_GET : REQ_SET;
					default: op = (r < 35) ? REQ_SET : (r < 70) ? REQ_GET : REQ_DEL;
				endcase
			end
			send_req(op, pick_key(), rand_value());
		end
	endtask

	initial begin
		key_pool[0] = K_MIN;
		key_pool[1] = K_MAX;
		key_pool[2] = K_ZERO;
		key_pool[3] = K_ONES;
		for (int i = 4; i < POOL_N; i++)
			key_pool[i] = rand_word();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_req(REQ_GET, K_MIN, K_ONES);
		send_req(REQ_SET, K_MIN, K_MAX);
		send_req(REQ_SET, K_MAX, K_MIN);
		send_req(REQ_GET, K_MIN, K_ZERO);
		send_req(REQ_GET, K_MAX, K_ZERO);
		send_req(REQ_SET, K_MIN, K_ZERO);
		send_req(REQ_GET, K_MIN, K_ONES);
		send_req(REQ_DEL, K_MAX, K_ONES);
		send_req(REQ_DEL, K_MAX, K_ZERO);
		send_req(REQ_GET, K_MAX, K_ZERO);
		send_req(REQ_SET, K_MAX, K_ONES);
		send_req(REQ_SET, K_ZERO, 64'd1);
		send_req(REQ_SET, K_ONES, K_MAX);
		send_req(REQ_GET, K_ZERO, K_ZERO);
		send_req(REQ_GET, K_ONES, K_ZERO);
		send_req(REQ_BAD, K_MIN, K_ONES);
		send_req(REQ_BAD, K_ZERO, K_ZERO);
		send_req(REQ_DEL, K_ZERO, K_ZERO);
		send_req(REQ_GET, K_ZERO, K_ZERO);
		send_req(REQ_DEL, K_MIN, K_ZERO);
		send_req(REQ_GET, K_MIN, K_ZERO);
		send_req(REQ_SET, K_MAX, K_MAX);
		wait_drained();

		for (int rnd = 0; rnd < ROUNDS; rnd++) begin
			random_round(rnd % 3, ROUND_ITEMS);
			if (rnd == ROUNDS / 2)
				wait_drained();
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("tb_linear_probe_hash_map_top passed");
		else
			$display("tb_linear_probe_hash_map_top failed");
		$finish;
	end

endmodule
